@@ hdl/phtc_pkg.sv @@
// ----------------------------------------------------------------------------
// phtc_pkg
// shared constants, register indexes and helper functions for the
// pressure, humidity and temperature compensation block
// ----------------------------------------------------------------------------
`default_nettype none

package phtc_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int DIV_W      = 32;

  localparam logic [CFG_IDX_W-1:0] REG_TEMP_CALIB       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_CALIB_LOW  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_CALIB_HIGH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_CALIB_NINE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HUM_CALIB_LOW    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HUM_CALIB_HIGH   = 3'd5;

  localparam logic [31:0] P_OFFSET   = 32'd64000;
  localparam logic [31:0] P_FULL     = 32'd1048576;
  localparam logic [31:0] P_SCALE    = 32'd3125;
  localparam logic [31:0] SIGN32     = 32'h8000_0000;
  localparam logic [31:0] H_OFFSET   = 32'd76800;
  localparam logic [31:0] H_MAX      = 32'h1900_0000;
  localparam logic [31:0] H_BIAS_W   = 32'd2097152;
  localparam logic [31:0] H_ROUND_U  = 32'd16384;
  localparam logic [31:0] P_BIAS_A   = 32'd32768;
  localparam logic [31:0] H_ROUND_W  = 32'd8192;
  localparam logic [31:0] T_ROUND    = 32'd128;

  function automatic logic [31:0] asr(input logic [31:0] v, input logic [4:0] s);
    asr = $unsigned($signed(v) >>> s);
  endfunction

  function automatic logic [31:0] sx16(input logic [15:0] v);
    sx16 = {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] sx8(input logic [7:0] v);
    sx8 = {{24{v[7]}}, v};
  endfunction

endpackage

`default_nettype wire

@@ hdl/pressure_humidity_temp_compensation.sv @@
// ----------------------------------------------------------------------------
// pressure_humidity_temp_compensation
// integer compensation of raw pressure, temperature and humidity samples
// ----------------------------------------------------------------------------
// One raw sample triple enters per cycle while in_ready is high; sustained
// rate is one transfer per clock while out_ready is high. There are eleven
// arithmetic stages ahead of a 32-stage pipelined divider (one quotient bit
// per stage) for pressure, and two correction stages after it. A two-entry
// output buffer lets the pipeline keep moving while one result waits.
// Calibration must be written only while the pipeline is empty.
// ----------------------------------------------------------------------------
`default_nettype none

module pressure_humidity_temp_compensation (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [phtc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [phtc_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [19:0]                         adc_pressure,
  input  wire logic [19:0]                         adc_temperature,
  input  wire logic [15:0]                         adc_humidity,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [21:0]                       temperature_centi,
  output logic [31:0]                              pressure_pa,
  output logic [16:0]                              humidity_q22_10,
  output logic                                     pressure_divisor_zero
);

  import phtc_pkg::*;

  localparam int SIDE_W = 22 + 17 + 1 + 1;

  logic [47:0] temp_calib;
  logic [63:0] press_calib_low;
  logic [63:0] press_calib_high;
  logic [15:0] press_calib_nine;
  logic [39:0] hum_calib_low;
  logic [31:0] hum_calib_high;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_calib       <= '0;
      press_calib_low  <= '0;
      press_calib_high <= '0;
      press_calib_nine <= '0;
      hum_calib_low    <= '0;
      hum_calib_high   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TEMP_CALIB:       temp_calib       <= cfg_data[47:0];
        REG_PRESS_CALIB_LOW:  press_calib_low  <= cfg_data;
        REG_PRESS_CALIB_HIGH: press_calib_high <= cfg_data;
        REG_PRESS_CALIB_NINE: press_calib_nine <= cfg_data[15:0];
        REG_HUM_CALIB_LOW:    hum_calib_low    <= cfg_data[39:0];
        REG_HUM_CALIB_HIGH:   hum_calib_high   <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
  logic [31:0] h1, h2, h3, h4, h5, h6;

  assign t1 = {16'd0, temp_calib[15:0]};
  assign t2 = sx16(temp_calib[31:16]);
  assign t3 = sx16(temp_calib[47:32]);
  assign p1 = {16'd0, press_calib_low[15:0]};
  assign p2 = sx16(press_calib_low[31:16]);
  assign p3 = sx16(press_calib_low[47:32]);
  assign p4 = sx16(press_calib_low[63:48]);
  assign p5 = sx16(press_calib_high[15:0]);
  assign p6 = sx16(press_calib_high[31:16]);
  assign p7 = sx16(press_calib_high[47:32]);
  assign p8 = sx16(press_calib_high[63:48]);
  assign p9 = sx16(press_calib_nine);
  assign h1 = {24'd0, hum_calib_low[7:0]};
  assign h2 = sx16(hum_calib_low[23:8]);
  assign h3 = {24'd0, hum_calib_low[31:24]};
  assign h6 = sx8(hum_calib_low[39:32]);
  assign h4 = sx16(hum_calib_high[15:0]);
  assign h5 = sx16(hum_calib_high[31:16]);

  logic        adv;
  logic [10:0] pv;
  logic [1:0]  qv;
  logic        dv_valid;

  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= '0;
      qv <= '0;
    end else if (adv) begin
      pv <= {pv[9:0], in_valid};
      qv <= {qv[0], dv_valid};
    end
  end

  // stage 1
  logic [31:0] s1_m1, s1_m2;
  logic [19:0] s1_adc_p;
  logic [15:0] s1_adc_h;
  logic [31:0] da, dt;

  assign da = {15'd0, adc_temperature[19:3]} - {15'd0, t1[15:0], 1'b0};
  assign dt = {16'd0, adc_temperature[19:4]} - t1;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_m1    <= da * t2;
      s1_m2    <= dt * dt;
      s1_adc_p <= adc_pressure;
      s1_adc_h <= adc_humidity;
    end
  end

  // stage 2
  logic [31:0] s2_a, s2_m3;
  logic [19:0] s2_adc_p;
  logic [15:0] s2_adc_h;

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_a     <= asr(s1_m1, 5'd11);
      s2_m3    <= asr(s1_m2, 5'd12) * t3;
      s2_adc_p <= s1_adc_p;
      s2_adc_h <= s1_adc_h;
    end
  end

  // stage 3: fine temperature
  logic [31:0] s3_fine;
  logic [19:0] s3_adc_p;
  logic [15:0] s3_adc_h;

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_fine  <= s2_a + asr(s2_m3, 5'd14);
      s3_adc_p <= s2_adc_p;
      s3_adc_h <= s2_adc_h;
    end
  end

  // stage 4
  logic [31:0] pa, qh, hx, tmp;
  logic [31:0] s4_q, s4_mp5, s4_mp2, s4_mh5, s4_mh6, s4_mh3;
  logic [21:0] s4_temp;
  logic [19:0] s4_adc_p;
  logic [15:0] s4_adc_h;

  assign pa  = asr(s3_fine, 5'd1) - P_OFFSET;
  assign qh  = asr(pa, 5'd2);
  assign hx  = s3_fine - H_OFFSET;
  assign tmp = asr({s3_fine[29:0], 2'b00} + s3_fine + T_ROUND, 5'd8);

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_q     <= qh * qh;
      s4_mp5   <= pa * p5;
      s4_mp2   <= p2 * pa;
      s4_mh5   <= h5 * hx;
      s4_mh6   <= hx * h6;
      s4_mh3   <= hx * h3;
      s4_temp  <= tmp[21:0];
      s4_adc_p <= s3_adc_p;
      s4_adc_h <= s3_adc_h;
    end
  end

  // stage 5
  logic [31:0] s5_b1, s5_mp3, s5_mp5, s5_mp2, s5_u, s5_wm;
  logic [21:0] s5_temp;
  logic [19:0] s5_adc_p;

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_b1    <= asr(s4_q, 5'd11) * p6;
      s5_mp3   <= p3 * asr(s4_q, 5'd13);
      s5_mp5   <= s4_mp5;
      s5_mp2   <= s4_mp2;
      s5_u     <= asr({2'b00, s4_adc_h, 14'd0} - {h4[11:0], 20'd0} - s4_mh5 + H_ROUND_U,
                      5'd15);
      s5_wm    <= asr(s4_mh6, 5'd10) * (asr(s4_mh3, 5'd11) + P_BIAS_A);
      s5_temp  <= s4_temp;
      s5_adc_p <= s4_adc_p;
    end
  end

  // stage 6
  logic [31:0] s6_b, s6_a2, s6_hw, s6_u;
  logic [21:0] s6_temp;
  logic [19:0] s6_adc_p;

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_b     <= asr(s5_b1 + {s5_mp5[30:0], 1'b0}, 5'd2) + {p4[15:0], 16'd0};
      s6_a2    <= asr(asr(s5_mp3, 5'd3) + asr(s5_mp2, 5'd1), 5'd18);
      s6_hw    <= (asr(s5_wm, 5'd10) + H_BIAS_W) * h2;
      s6_u     <= s5_u;
      s6_temp  <= s5_temp;
      s6_adc_p <= s5_adc_p;
    end
  end

  // stage 7
  logic [31:0] s7_a3, s7_pn, s7_w, s7_u;
  logic [21:0] s7_temp;

  always_ff @(posedge clk) begin
    if (adv) begin
      s7_a3   <= (P_BIAS_A + s6_a2) * p1;
      s7_pn   <= (P_FULL - {12'd0, s6_adc_p}) - asr(s6_b, 5'd12);
      s7_w    <= asr(s6_hw + H_ROUND_W, 5'd14);
      s7_u    <= s6_u;
      s7_temp <= s6_temp;
    end
  end

  // stage 8
  logic [31:0] s8_div, s8_pm, s8_hx;
  logic [21:0] s8_temp;

  always_ff @(posedge clk) begin
    if (adv) begin
      s8_div  <= asr(s7_a3, 5'd15);
      s8_pm   <= s7_pn * P_SCALE;
      s8_hx   <= s7_u * s7_w;
      s8_temp <= s7_temp;
    end
  end

  // stage 9
  logic [31:0] y9;
  logic [31:0] s9_dvd, s9_div, s9_yy, s9_hx;
  logic        s9_dz, s9_mode;
  logic [21:0] s9_temp;

  assign y9 = asr(s8_hx, 5'd15);

  always_ff @(posedge clk) begin
    if (adv) begin
      s9_mode <= (s8_pm >= SIGN32);
      s9_dvd  <= (s8_pm >= SIGN32) ? s8_pm : {s8_pm[30:0], 1'b0};
      s9_dz   <= (s8_div == '0);
      s9_div  <= s8_div;
      s9_yy   <= y9 * y9;
      s9_hx   <= s8_hx;
      s9_temp <= s8_temp;
    end
  end

  // stage 10
  logic [31:0] s10_dvd, s10_div, s10_hh, s10_hx;
  logic        s10_dz, s10_mode;
  logic [21:0] s10_temp;

  always_ff @(posedge clk) begin
    if (adv) begin
      s10_hh   <= asr(s9_yy, 5'd7) * h1;
      s10_hx   <= s9_hx;
      s10_dvd  <= s9_dvd;
      s10_div  <= s9_div;
      s10_dz   <= s9_dz;
      s10_mode <= s9_mode;
      s10_temp <= s9_temp;
    end
  end

  // stage 11: humidity clamp
  logic [31:0] hx11;
  logic [31:0] s11_dvd, s11_div;
  logic        s11_dz, s11_mode;
  logic [21:0] s11_temp;
  logic [16:0] s11_hum;

  assign hx11 = s10_hx - asr(s10_hh, 5'd4);

  always_ff @(posedge clk) begin
    if (adv) begin
      if (hx11[31]) begin
        s11_hum <= '0;
      end else if (hx11 > H_MAX) begin
        s11_hum <= H_MAX[28:12];
      end else begin
        s11_hum <= hx11[28:12];
      end
      s11_dvd  <= s10_dvd;
      s11_div  <= s10_div;
      s11_dz   <= s10_dz;
      s11_mode <= s10_mode;
      s11_temp <= s10_temp;
    end
  end

  // pressure division
  logic [31:0]       quo;
  logic [SIDE_W-1:0] side_o;

  phtc_div #(
    .W      (DIV_W),
    .SIDE_W (SIDE_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (pv[10]),
    .dividend  (s11_dvd),
    .divisor   (s11_div),
    .side      ({s11_temp, s11_hum, s11_dz, s11_mode}),
    .out_valid (dv_valid),
    .quotient  (quo),
    .side_out  (side_o)
  );

  // correction stage 1
  logic [31:0] pq;
  logic [31:0] s12_press, s12_sq, s12_mw;
  logic [21:0] s12_temp;
  logic [16:0] s12_hum;
  logic        s12_dz;

  assign pq = side_o[0] ? {quo[30:0], 1'b0} : quo;

  always_ff @(posedge clk) begin
    if (adv) begin
      s12_press <= pq;
      s12_sq    <= {3'd0, pq[31:3]} * {3'd0, pq[31:3]};
      s12_mw    <= {2'd0, pq[31:2]} * p8;
      s12_temp  <= side_o[40:19];
      s12_hum   <= side_o[18:2];
      s12_dz    <= side_o[1];
    end
  end

  // correction stage 2
  logic [31:0] s13_press, s13_mu, s13_w;
  logic [21:0] s13_temp;
  logic [16:0] s13_hum;
  logic        s13_dz;

  always_ff @(posedge clk) begin
    if (adv) begin
      s13_press <= s12_press;
      s13_mu    <= p9 * {13'd0, s12_sq[31:13]};
      s13_w     <= asr(s12_mw, 5'd13);
      s13_temp  <= s12_temp;
      s13_hum   <= s12_hum;
      s13_dz    <= s12_dz;
    end
  end

  logic [31:0] pfinal;

  assign pfinal = s13_dz ? '0
                : s13_press + asr(asr(s13_mu, 5'd12) + s13_w + p7, 5'd4);

  // output register with skid entry
  logic        push, pop, skid_valid;
  logic [21:0] skid_temp;
  logic [31:0] skid_press;
  logic [16:0] skid_hum;
  logic        skid_dz;

  assign adv  = !skid_valid;
  assign push = adv && qv[1];
  assign pop  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      out_valid  <= skid_valid || push;
      skid_valid <= 1'b0;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || pop) begin
      if (skid_valid) begin
        temperature_centi     <= $signed(skid_temp);
        pressure_pa           <= skid_press;
        humidity_q22_10       <= skid_hum;
        pressure_divisor_zero <= skid_dz;
      end else begin
        temperature_centi     <= $signed(s13_temp);
        pressure_pa           <= pfinal;
        humidity_q22_10       <= s13_hum;
        pressure_divisor_zero <= s13_dz;
      end
    end
    if (push) begin
      skid_temp  <= s13_temp;
      skid_press <= pfinal;
      skid_hum   <= s13_hum;
      skid_dz    <= s13_dz;
    end
  end

endmodule

`default_nettype wire

@@ hdl/phtc_div.sv @@
// ----------------------------------------------------------------------------
// phtc_div
// pipelined unsigned restoring divider, one quotient bit per stage, with a
// sideband that travels alongside the operands
// ----------------------------------------------------------------------------
`default_nettype none

module phtc_div #(
  parameter int W      = phtc_pkg::DIV_W,
  parameter int SIDE_W = 1
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire logic [W-1:0]      dividend,
  input  wire logic [W-1:0]      divisor,
  input  wire logic [SIDE_W-1:0] side,
  output logic                   out_valid,
  output logic [W-1:0]           quotient,
  output logic [SIDE_W-1:0]      side_out
);

  import phtc_pkg::*;

  logic [W-1:0]      vld;
  logic [W-1:0]      rem  [W];
  logic [W-1:0]      nq   [W];
  logic [W-1:0]      dvs  [W];
  logic [SIDE_W-1:0] sb   [W];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[W-2:0], in_valid};
    end
  end

  for (genvar i = 0; i < W; i++) begin : g_stage
    logic [W-1:0]      rem_in;
    logic [W-1:0]      nq_in;
    logic [W-1:0]      dvs_in;
    logic [SIDE_W-1:0] sb_in;
    logic [W:0]        trial;
    logic [W:0]        diff;

    if (i == 0) begin : g_first
      assign rem_in = '0;
      assign nq_in  = dividend;
      assign dvs_in = divisor;
      assign sb_in  = side;
    end else begin : g_rest
      assign rem_in = rem[i-1];
      assign nq_in  = nq[i-1];
      assign dvs_in = dvs[i-1];
      assign sb_in  = sb[i-1];
    end

    assign trial = {rem_in, nq_in[W-1]};
    assign diff  = trial - {1'b0, dvs_in};

    always_ff @(posedge clk) begin
      if (en) begin
        if (!diff[W]) begin
          rem[i] <= diff[W-1:0];
          nq[i]  <= {nq_in[W-2:0], 1'b1};
        end else begin
          rem[i] <= trial[W-1:0];
          nq[i]  <= {nq_in[W-2:0], 1'b0};
        end
        dvs[i] <= dvs_in;
        sb[i]  <= sb_in;
      end
    end
  end

  assign out_valid = vld[W-1];
  assign quotient  = nq[W-1];
  assign side_out  = sb[W-1];

endmodule

`default_nettype wire

@@ hdl/phtc_checker.sv @@
// ----------------------------------------------------------------------------
// phtc_checker
// port-level checks for the compensation block
// ----------------------------------------------------------------------------
`default_nettype none

module phtc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] pressure_pa,
  input wire logic [16:0] humidity_q22_10,
  input wire logic        pressure_divisor_zero
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pressure_pa))
    else $error("stalled result dropped or changed");

  a_hum_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> humidity_q22_10 <= 17'd102400)
    else $error("humidity above full scale");

  a_divzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && pressure_divisor_zero |-> pressure_pa == 32'd0)
    else $error("pressure not forced to zero on zero divisor");

endmodule

bind pressure_humidity_temp_compensation phtc_checker u_phtc_checker (
  .clk                   (clk),
  .rst                   (rst),
  .out_valid             (out_valid),
  .out_ready             (out_ready),
  .pressure_pa           (pressure_pa),
  .humidity_q22_10       (humidity_q22_10),
  .pressure_divisor_zero (pressure_divisor_zero)
);

`default_nettype wire
